// ===== sv/mase_pkg.sv =====
// ----------------------------------------------------------------------------
// mase_pkg: shared types, codes and the ALU function of the execute block
// Instruction field positions, opcode and funct codes, and one-pass execute.
// ----------------------------------------------------------------------------
package mase_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned RF_DEPTH = 32;
    localparam int unsigned REG_W    = 5;
    localparam int unsigned CODE_W   = 6;

    localparam logic [DATA_W-1:0] PC_STEP = 32'd4;

    // opcodes
    localparam logic [CODE_W-1:0] OP_RTYPE = 6'd0;
    localparam logic [CODE_W-1:0] OP_ADDI  = 6'd8;
    localparam logic [CODE_W-1:0] OP_ADDIU = 6'd9;
    localparam logic [CODE_W-1:0] OP_SLTI  = 6'd10;
    localparam logic [CODE_W-1:0] OP_SLTIU = 6'd11;
    localparam logic [CODE_W-1:0] OP_ANDI  = 6'd12;
    localparam logic [CODE_W-1:0] OP_ORI   = 6'd13;
    localparam logic [CODE_W-1:0] OP_XORI  = 6'd14;
    localparam logic [CODE_W-1:0] OP_LUI   = 6'd15;

    // funct codes
    localparam logic [CODE_W-1:0] FN_SLL  = 6'd0;
    localparam logic [CODE_W-1:0] FN_SRL  = 6'd2;
    localparam logic [CODE_W-1:0] FN_SRA  = 6'd3;
    localparam logic [CODE_W-1:0] FN_SLLV = 6'd4;
    localparam logic [CODE_W-1:0] FN_SRLV = 6'd6;
    localparam logic [CODE_W-1:0] FN_SRAV = 6'd7;
    localparam logic [CODE_W-1:0] FN_ADD  = 6'd32;
    localparam logic [CODE_W-1:0] FN_ADDU = 6'd33;
    localparam logic [CODE_W-1:0] FN_SUB  = 6'd34;
    localparam logic [CODE_W-1:0] FN_SUBU = 6'd35;
    localparam logic [CODE_W-1:0] FN_AND  = 6'd36;
    localparam logic [CODE_W-1:0] FN_OR   = 6'd37;
    localparam logic [CODE_W-1:0] FN_XOR  = 6'd38;
    localparam logic [CODE_W-1:0] FN_NOR  = 6'd39;
    localparam logic [CODE_W-1:0] FN_SLT  = 6'd42;
    localparam logic [CODE_W-1:0] FN_SLTU = 6'd43;

    typedef struct packed {
        logic              ok;
        logic [REG_W-1:0]  dest;
        logic [DATA_W-1:0] val;
    } t_alu_res;

    // Execute one instruction on operands a (rs) and b (rt).
    function automatic t_alu_res alu_exec(input logic [DATA_W-1:0] ins,
                                          input logic [DATA_W-1:0] a,
                                          input logic [DATA_W-1:0] b);
        t_alu_res          res;
        logic [CODE_W-1:0] op;
        logic [CODE_W-1:0] fn;
        logic [REG_W-1:0]  sh;
        logic [REG_W-1:0]  vsh;
        logic [DATA_W-1:0] imm;
        logic [DATA_W-1:0] simm;
        op   = ins[31:26];
        fn   = ins[5:0];
        sh   = ins[10:6];
        vsh  = a[REG_W-1:0];
        imm  = {16'd0, ins[15:0]};
        simm = {{16{ins[15]}}, ins[15:0]};
        res.ok  = 1'b1;
        res.val = '0;
        if (op == OP_RTYPE) begin
            res.dest = ins[15:11];
            unique case (fn)
                FN_SLL:           res.val = b << sh;
                FN_SRL:           res.val = b >> sh;
                FN_SRA:           res.val = DATA_W'($signed(b) >>> sh);
                FN_SLLV:          res.val = b << vsh;
                FN_SRLV:          res.val = b >> vsh;
                FN_SRAV:          res.val = DATA_W'($signed(b) >>> vsh);
                FN_ADD, FN_ADDU:  res.val = a + b;
                FN_SUB, FN_SUBU:  res.val = a - b;
                FN_AND:           res.val = a & b;
                FN_OR:            res.val = a | b;
                FN_XOR:           res.val = a ^ b;
                FN_NOR:           res.val = ~(a | b);
                FN_SLT:           res.val = {31'd0, $signed(a) < $signed(b)};
                FN_SLTU:          res.val = {31'd0, a < b};
                default:          res.ok  = 1'b0;
            endcase
        end else begin
            res.dest = ins[20:16];
            unique case (op)
                OP_ADDI, OP_ADDIU: res.val = a + simm;
                OP_SLTI:           res.val = {31'd0, $signed(a) < $signed(simm)};
                OP_SLTIU:          res.val = {31'd0, a < simm};
                OP_ANDI:           res.val = a & imm;
                OP_ORI:            res.val = a | imm;
                OP_XORI:           res.val = a ^ imm;
                OP_LUI:            res.val = {ins[15:0], 16'd0};
                default:           res.ok  = 1'b0;
            endcase
        end
        return res;
    endfunction

endpackage

// ===== sv/mase_ram.sv =====
// ----------------------------------------------------------------------------
// mase_ram: generic RAM, one write port and two registered read ports
// Read data updates only on a read enable; a read at the written address
// in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module mase_ram #(
    parameter int unsigned WIDTH = mase_pkg::DATA_W,
    parameter int unsigned DEPTH = mase_pkg::RF_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== sv/mips_alu_subset_execute.sv =====
// ----------------------------------------------------------------------------
// mips_alu_subset_execute: MIPS32 integer ALU subset with register file
// Executes one instruction word per item against a 32 x 32 register file.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_ready carry i_instruction. Output channel:
//   o_valid / i_ready carry o_status, o_next_pc, o_write_enable,
//   o_dest_register and o_write_value, one result item per instruction.
//   Stage 1 registers the instruction together with the two register-file
//   reads (the RAM read port is registered); stage 2 is the result
//   register, loaded from the one-pass ALU. The register file write happens
//   as an item leaves stage 1, and a bypass captured at acceptance covers
//   the item right behind it, so dependent instructions follow with no
//   bubble.
//   Throughput: one item per cycle while the receiver takes results.
//   Reset: valid bits of all 32 registers clear, so every register reads
//   as zero at once; the program counter clears to zero; both stages
//   empty. No clearing pass is needed.
//   Stall: when i_ready is low with a result waiting, the result register
//   holds, stage 1 holds its item; o_ready drops only when both are full.
//   Register 0 is never written and always reads as zero.
// ----------------------------------------------------------------------------
module mips_alu_subset_execute (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [mase_pkg::DATA_W-1:0]  i_instruction,
    // output channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_status,
    output logic [mase_pkg::DATA_W-1:0]  o_next_pc,
    output logic                         o_write_enable,
    output logic [mase_pkg::REG_W-1:0]   o_dest_register,
    output logic [mase_pkg::DATA_W-1:0]  o_write_value
);

    localparam int unsigned DW = mase_pkg::DATA_W;
    localparam int unsigned RW = mase_pkg::REG_W;
    localparam int unsigned RD = mase_pkg::RF_DEPTH;

    // stage 1: instruction, read qualifiers, bypass
    logic          r_s1_valid;
    logic [DW-1:0] r_s1_ins;
    logic          r_a_vld, r_b_vld;
    logic          r_a_byp, r_b_byp;
    logic [DW-1:0] r_byp_val;

    // register-file bookkeeping and program counter
    logic [RD-1:0] r_rf_vld;
    logic [DW-1:0] r_pc;
    logic [DW-1:0] n_pc;

    // stage 2: result register
    logic          r_o_valid;
    logic          r_o_status;
    logic [DW-1:0] r_o_next_pc;
    logic          r_o_we;
    logic [RW-1:0] r_o_dest;
    logic [DW-1:0] r_o_val;

    logic          in_fire;
    logic          s1_adv;
    logic          s1_fire;
    logic [RW-1:0] rs_new, rt_new;
    logic [DW-1:0] ram_a, ram_b;
    logic [DW-1:0] op_a, op_b;
    logic          wr_en;

    mase_pkg::t_alu_res alu;

    // handshakes: stage 2 frees when empty or taken; stage 1 follows
    assign s1_adv  = !r_o_valid || i_ready;
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_fire = i_valid && o_ready;
    assign s1_fire = r_s1_valid && s1_adv;

    assign rs_new = i_instruction[25:21];
    assign rt_new = i_instruction[20:16];

    // operands: bypass from the item ahead, else stored value, else zero
    always_comb begin
        priority if (r_a_byp) op_a = r_byp_val;
        else if (r_a_vld)     op_a = ram_a;
        else                  op_a = '0;
        priority if (r_b_byp) op_b = r_byp_val;
        else if (r_b_vld)     op_b = ram_b;
        else                  op_b = '0;
    end

    assign alu   = mase_pkg::alu_exec(r_s1_ins, op_a, op_b);
    // write only known instructions to a nonzero register
    assign wr_en = s1_fire && alu.ok && (alu.dest != '0);
    assign n_pc  = r_pc + mase_pkg::PC_STEP;

    mase_ram #(
        .WIDTH (DW),
        .DEPTH (RD)
    ) u_rf (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (alu.dest),
        .i_wdata   (alu.val),
        .i_re      (in_fire),
        .i_raddr_a (rs_new),
        .i_raddr_b (rt_new),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // stage 1 control and read qualifiers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (in_fire) begin
            r_s1_ins  <= i_instruction;
            r_a_vld   <= r_rf_vld[rs_new];
            r_b_vld   <= r_rf_vld[rt_new];
            // the item leaving stage 1 now writes too late for the RAM read
            r_a_byp   <= wr_en && (alu.dest == rs_new);
            r_b_byp   <= wr_en && (alu.dest == rt_new);
            r_byp_val <= alu.val;
        end
    end

    // valid bits and program counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_pc     <= '0;
        end else begin
            if (wr_en) begin
                r_rf_vld[alu.dest] <= 1'b1;
            end
            if (s1_fire) begin
                r_pc <= n_pc;
            end
        end
    end

    // result register: advance on s1_fire, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= r_s1_valid;
        end
        if (s1_fire) begin
            r_o_status  <= !alu.ok;
            r_o_next_pc <= n_pc;
            r_o_we      <= alu.ok && (alu.dest != '0);
            r_o_dest    <= alu.ok ? alu.dest : '0;
            r_o_val     <= alu.ok ? alu.val : '0;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_next_pc       = r_o_next_pc;
    assign o_write_enable  = r_o_we;
    assign o_dest_register = r_o_dest;
    assign o_write_value   = r_o_val;

    // register 0 is never written
    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (alu.dest != '0))
        else $error("write to register zero");

    // program counter steps by four with each item leaving stage 1
    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (r_pc == $past(r_pc) + mase_pkg::PC_STEP))
        else $error("program counter did not advance by four");

    // input blocks only when both stages are full and the output stalls
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_s1_valid && r_o_valid && !i_ready))
        else $error("input blocked with room in the pipeline");

    // an unknown instruction reports no write
    a_unknown_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status) |-> (!r_o_we && (r_o_val == '0)))
        else $error("unknown instruction shows a write");

endmodule

// ===== test/mips_alu_subset_execute_tb.sv =====
// ----------------------------------------------------------------------------
// mips_alu_subset_execute_tb: self-checking bench for the MIPS ALU subset
// Drives instruction words through the valid/ready input, tracks a private
// copy of the register file and program counter, and compares every retired
// result field by field. A directed table comes first, then random
// instruction streams with bursty input and a receiver that stalls.
// ----------------------------------------------------------------------------
module mips_alu_subset_execute_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DW = mase_pkg::DATA_W;
    localparam int unsigned RW = mase_pkg::REG_W;
    localparam int unsigned CW = mase_pkg::CODE_W;
    localparam int unsigned RD = mase_pkg::RF_DEPTH;

    // Opcode outside the supported subset (a load), used as a directed case.
    localparam logic [CW-1:0] OP_LW_UNSUPPORTED = 6'h23;

    localparam int unsigned RANDOM_ITEMS = 1420;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned LIMIT_CYCLES = 200_000;

    // One retired instruction as seen on the output channel.
    typedef struct packed {
        logic          status;
        logic [DW-1:0] next_pc;
        logic          we;
        logic [RW-1:0] dest;
        logic [DW-1:0] value;
    } t_retire;

    typedef struct {
        logic [DW-1:0] word;
        bit            typed;
        t_retire       want;
    } t_plan_row;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_valid       = 1'b0;
    logic [DW-1:0] i_instruction = '0;
    logic          i_ready       = 1'b0;
    logic          o_ready;
    logic          o_valid;
    logic          o_status;
    logic [DW-1:0] o_next_pc;
    logic          o_write_enable;
    logic [RW-1:0] o_dest_register;
    logic [DW-1:0] o_write_value;

    // Private architectural state, advanced as items are accepted.
    logic [DW-1:0] gpr [RD];
    logic [DW-1:0] arch_pc;

    t_retire     retire_q[$];
    t_plan_row   plan[$];
    int unsigned n_errors    = 0;
    int unsigned n_checked   = 0;
    int unsigned n_sent      = 0;
    int unsigned n_unknown   = 0;
    int unsigned n_writes    = 0;
    int unsigned n_zero_dest = 0;
    int unsigned cycle_count = 0;
    bit          hold_off_req = 1'b0;

    mips_alu_subset_execute DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_instruction   (i_instruction),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_next_pc       (o_next_pc),
        .o_write_enable  (o_write_enable),
        .o_dest_register (o_dest_register),
        .o_write_value   (o_write_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Instruction encoding
    // ------------------------------------------------------------------------
    function automatic logic [DW-1:0] enc_r(input logic [RW-1:0] rs,
                                            input logic [RW-1:0] rt,
                                            input logic [RW-1:0] rd,
                                            input logic [RW-1:0] sh,
                                            input logic [CW-1:0] fn);
        return {mase_pkg::OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [DW-1:0] enc_i(input logic [CW-1:0] op,
                                            input logic [RW-1:0] rs,
                                            input logic [RW-1:0] rt,
                                            input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: execute one word on the private state, return what retires
    // ------------------------------------------------------------------------
    function automatic t_retire predict_execution(input logic [DW-1:0] word);
        t_retire       r;
        logic [CW-1:0] opc;
        logic [CW-1:0] fnc;
        logic [RW-1:0] amt;
        logic [RW-1:0] dst;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [DW-1:0] zimm;
        logic [DW-1:0] simm;
        logic [DW-1:0] v;
        logic          known;
        opc   = word[31:26];
        fnc   = word[5:0];
        amt   = word[10:6];
        a     = gpr[word[25:21]];
        b     = gpr[word[20:16]];
        zimm  = {16'h0000, word[15:0]};
        simm  = {{16{word[15]}}, word[15:0]};
        v     = '0;
        known = 1'b1;
        arch_pc = arch_pc + mase_pkg::PC_STEP;
        if (opc == mase_pkg::OP_RTYPE) begin
            dst = word[15:11];
            // variable shifts take the amount from the low bits of rs
            if (fnc == mase_pkg::FN_SLLV || fnc == mase_pkg::FN_SRLV ||
                fnc == mase_pkg::FN_SRAV) amt = a[RW-1:0];
            case (fnc)
                mase_pkg::FN_SLL, mase_pkg::FN_SLLV: v = b << amt;
                mase_pkg::FN_SRL, mase_pkg::FN_SRLV: v = b >> amt;
                mase_pkg::FN_SRA, mase_pkg::FN_SRAV: v = $signed(b) >>> amt;
                mase_pkg::FN_ADD, mase_pkg::FN_ADDU: v = a + b;
                mase_pkg::FN_SUB, mase_pkg::FN_SUBU: v = a - b;
                mase_pkg::FN_AND:  v = a & b;
                mase_pkg::FN_OR:   v = a | b;
                mase_pkg::FN_XOR:  v = a ^ b;
                mase_pkg::FN_NOR:  v = ~(a | b);
                mase_pkg::FN_SLT:  v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                mase_pkg::FN_SLTU: v = (a < b) ? 32'd1 : 32'd0;
                default:           known = 1'b0;
            endcase
        end else begin
            dst = word[20:16];
            case (opc)
                mase_pkg::OP_ADDI, mase_pkg::OP_ADDIU: v = a + simm;
                mase_pkg::OP_SLTI:  v = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                mase_pkg::OP_SLTIU: v = (a < simm) ? 32'd1 : 32'd0;
                mase_pkg::OP_ANDI:  v = a & zimm;
                mase_pkg::OP_ORI:   v = a | zimm;
                mase_pkg::OP_XORI:  v = a ^ zimm;
                mase_pkg::OP_LUI:   v = {word[15:0], 16'h0000};
                default:            known = 1'b0;
            endcase
        end
        r.next_pc = arch_pc;
        if (!known) begin
            // unknown word: nothing written, result fields cleared
            r.status = 1'b1;
            r.we     = 1'b0;
            r.dest   = '0;
            r.value  = '0;
        end else begin
            // register zero shows the value but keeps reading as zero
            r.status = 1'b0;
            r.we     = (dst != '0);
            r.dest   = dst;
            r.value  = v;
            if (dst != '0) gpr[dst] = v;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random instruction words
    // ------------------------------------------------------------------------
    // Favor a few low registers so results feed straight into the next items.
    function automatic logic [RW-1:0] pick_reg();
        return ($urandom_range(0, 3) != 0) ? RW'($urandom_range(0, 7)) : RW'($urandom);
    endfunction

    function automatic logic [DW-1:0] random_word();
        int unsigned   pick;
        logic [CW-1:0] code;
        logic [15:0]   imm;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 11))
            0:       imm = 16'h0000;
            1:       imm = 16'h7FFF;
            2:       imm = 16'h8000;
            3:       imm = 16'hFFFF;
            default: imm = 16'($urandom);
        endcase
        // raw noise toggles every bit of the word
        if (pick < 8) return $urandom;
        // R-type with any funct, mostly unsupported ones
        if (pick < 12) return enc_r(pick_reg(), pick_reg(), pick_reg(), RW'($urandom),
                                    CW'($urandom));
        // unsupported opcode: shift the I-type block out of the way
        if (pick < 16) begin
            code = CW'($urandom_range(1, 63));
            if (code >= mase_pkg::OP_ADDI && code <= mase_pkg::OP_LUI) code = code + 6'd8;
            return enc_i(code, pick_reg(), pick_reg(), imm);
        end
        if (pick < 55) begin
            case ($urandom_range(0, 15))
                0:       code = mase_pkg::FN_SLL;
                1:       code = mase_pkg::FN_SRL;
                2:       code = mase_pkg::FN_SRA;
                3:       code = mase_pkg::FN_SLLV;
                4:       code = mase_pkg::FN_SRLV;
                5:       code = mase_pkg::FN_SRAV;
                6:       code = mase_pkg::FN_ADD;
                7:       code = mase_pkg::FN_ADDU;
                8:       code = mase_pkg::FN_SUB;
                9:       code = mase_pkg::FN_SUBU;
                10:      code = mase_pkg::FN_AND;
                11:      code = mase_pkg::FN_OR;
                12:      code = mase_pkg::FN_XOR;
                13:      code = mase_pkg::FN_NOR;
                14:      code = mase_pkg::FN_SLT;
                default: code = mase_pkg::FN_SLTU;
            endcase
            // shamt stays random for every funct, it must be ignored where unused
            return enc_r(pick_reg(), pick_reg(), pick_reg(), RW'($urandom), code);
        end
        // supported I-type codes run contiguously from addi to lui
        code = mase_pkg::OP_ADDI + CW'($urandom_range(0, 7));
        return enc_i(code, pick_reg(), pick_reg(), imm);
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one item, hold it until accepted, then record what it must retire.
    task automatic issue(input logic [DW-1:0] word, input bit typed = 1'b0,
                         input t_retire want = '0);
        t_retire predicted;
        i_valid       <= 1'b1;
        i_instruction <= word;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predicted = predict_execution(word);
        retire_q.push_back(typed ? want : predicted);
        n_sent++;
        if (predicted.status)  n_unknown++;
        else if (predicted.we) n_writes++;
        else                   n_zero_dest++;
    endtask

    // Drop valid and hold until every expected result has retired.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (retire_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [DW-1:0] word, input bit typed = 1'b0,
                           input t_retire want = '0);
        t_plan_row row;
        row.word  = word;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    initial begin : stimulus
        int unsigned burst_left;
        int unsigned gap;
        for (int k = 0; k < RD; k++) gpr[k] = '0;
        arch_pc = '0;

        // Directed table. The first rows and the unknown words carry their
        // result typed in; the program counter is four times the row number.
        add_row(enc_i(mase_pkg::OP_LUI, 5'd0, 5'd1, 16'hFFFF), 1'b1,
                '{1'b0, 32'd4, 1'b1, 5'd1, 32'hFFFF_0000});
        add_row(enc_i(mase_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF), 1'b1,
                '{1'b0, 32'd8, 1'b1, 5'd1, 32'hFFFF_FFFF});
        add_row(32'hFFFF_FFFF, 1'b1, '{1'b1, 32'd12, 1'b0, 5'd0, 32'd0});
        add_row(enc_r(5'd0, 5'd0, 5'd0, 5'd0, 6'd1), 1'b1,
                '{1'b1, 32'd16, 1'b0, 5'd0, 32'd0});
        // lui into register zero with rs set: value shown, nothing written
        add_row(enc_i(mase_pkg::OP_LUI, 5'd31, 5'd0, 16'h8000), 1'b1,
                '{1'b0, 32'd20, 1'b0, 5'd0, 32'h8000_0000});
        add_row(enc_r(5'd1, 5'd1, 5'd0, 5'd0, mase_pkg::FN_ADDU));
        add_row(enc_r(5'd1, 5'd1, 5'd2, 5'd31, mase_pkg::FN_ADD));
        add_row(enc_r(5'd0, 5'd1, 5'd3, 5'd0, mase_pkg::FN_SUB));
        add_row(enc_r(5'd31, 5'd1, 5'd4, 5'd31, mase_pkg::FN_SLL));
        add_row(enc_r(5'd0, 5'd4, 5'd5, 5'd31, mase_pkg::FN_SRL));
        add_row(enc_r(5'd0, 5'd4, 5'd6, 5'd31, mase_pkg::FN_SRA));
        add_row(enc_r(5'd5, 5'd1, 5'd7, 5'd0, mase_pkg::FN_SLLV));
        add_row(enc_r(5'd2, 5'd4, 5'd8, 5'd0, mase_pkg::FN_SRLV));
        add_row(enc_r(5'd1, 5'd4, 5'd9, 5'd0, mase_pkg::FN_SRAV));
        add_row(enc_r(5'd1, 5'd4, 5'd10, 5'd0, mase_pkg::FN_SUBU));
        add_row(enc_r(5'd4, 5'd5, 5'd11, 5'd0, mase_pkg::FN_SLT));
        add_row(enc_r(5'd4, 5'd5, 5'd12, 5'd0, mase_pkg::FN_SLTU));
        add_row(enc_r(5'd4, 5'd6, 5'd13, 5'd0, mase_pkg::FN_AND));
        add_row(enc_r(5'd4, 5'd5, 5'd14, 5'd0, mase_pkg::FN_OR));
        add_row(enc_r(5'd4, 5'd1, 5'd15, 5'd0, mase_pkg::FN_XOR));
        add_row(enc_r(5'd4, 5'd5, 5'd16, 5'd0, mase_pkg::FN_NOR));
        add_row(enc_i(mase_pkg::OP_ADDI, 5'd0, 5'd17, 16'h8000));
        add_row(enc_i(mase_pkg::OP_ADDIU, 5'd17, 5'd17, 16'h7FFF));
        add_row(enc_i(mase_pkg::OP_SLTI, 5'd4, 5'd18, 16'hFFFF));
        add_row(enc_i(mase_pkg::OP_SLTIU, 5'd5, 5'd19, 16'hFFFF));
        add_row(enc_i(mase_pkg::OP_ANDI, 5'd1, 5'd20, 16'h8001));
        add_row(enc_i(mase_pkg::OP_XORI, 5'd1, 5'd31, 16'hFFFF));
        add_row(enc_i(OP_LW_UNSUPPORTED, 5'd31, 5'd31, 16'hFFFF), 1'b1,
                '{1'b1, 32'd112, 1'b0, 5'd0, 32'd0});

        // Hold reset, then release it once.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) issue(plan[k].word, plan[k].typed, plan[k].want);
        // pause the sender until the directed results are all back
        drain_results();

        burst_left = 0;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            // hold the receiver off and keep offering back to back so the
            // pipeline fills and the input stalls
            if (n == 300) begin
                hold_off_req = 1'b1;
                burst_left   = 100;
            end
            // mid-run pause: nothing offered until the pipeline is empty
            if (n == 800) begin
                drain_results();
                burst_left = 0;
            end
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            issue(random_word());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d instructions: %0d register writes, %0d to register zero,",
                 n_sent, n_writes, n_zero_dest);
        $display("%0d unknown words; %0d results checked against the predictor",
                 n_unknown, n_checked);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: stall pattern of its own plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver_pacing
        int unsigned hold_left;
        int unsigned seg_left;
        int unsigned mode;
        int unsigned phase;
        hold_left = 0;
        seg_left  = 0;
        mode      = 0;
        phase     = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_left != 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_ready     <= 1'b0;
            end else begin
                // pick a new stall style every segment; mode 0 never stalls
                if (seg_left == 0) begin
                    seg_left = $urandom_range(16, 120);
                    mode     = $urandom_range(0, 3);
                end
                seg_left--;
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(0, 1) != 0);
                    2:       i_ready <= ($urandom_range(0, 3) != 0);
                    default: i_ready <= ((phase % 5) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each retired item with the oldest expectation
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [DW-1:0] want,
                                        input logic [DW-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_retire want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (retire_q.size() == 0) begin
                $error("result retired with no instruction outstanding");
                n_errors++;
            end else begin
                want = retire_q.pop_front();
                check_field("status", DW'(want.status), DW'(o_status));
                check_field("next_pc", want.next_pc, o_next_pc);
                check_field("write_enable", DW'(want.we), DW'(o_write_enable));
                check_field("dest_register", DW'(want.dest), DW'(o_dest_register));
                check_field("write_value", want.value, o_write_value);
                n_checked++;
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, retire_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
